/* sv/ice_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ice_pkg
// Shared widths, reset constant and payload types of the consensus estimator.
// ----------------------------------------------------------------------------
package ice_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned GROUP_W  = 7;

  localparam logic [SAMPLE_W-1:0] WINDOW_RESET = 24'd500;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_distance;
    logic                last_of_list;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] consensus_distance;
    logic [GROUP_W-1:0]  samples_averaged;
    logic                overflowed;
  } out_item_t;

endpackage

/* sv/ice_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ice_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ice_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/interval_consensus_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_consensus_estimator
// Loads a list of distance samples and returns one consensus distance per list.
// ----------------------------------------------------------------------------
// Samples are kept in ascending order in one RAM: each accepted sample is
// insertion-sorted on arrival, shifting larger entries up one per cycle. The
// transfer marked last_of_list then starts evaluation: for n stored samples a
// two-pointer cluster scan (only for n >= 4), a sum over the chosen group of
// m samples, and a bit-serial divide. Three samples skip the scan, sum and
// divide: the chosen pair is halved with a shift. Input is not taken during
// evaluation; a finished result waits in the output register while the next
// list loads. Samples beyond MAX_SAMPLES are dropped and the result is
// flagged overflowed.
module interval_consensus_estimator #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ice_pkg::SAMPLE_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ice_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ice_pkg::out_item_t             out_data_o
);

  localparam int unsigned SW_ = ice_pkg::SAMPLE_W;
  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = SW_ + CW;
  localparam int unsigned DCW = $clog2(SUMW + 1);
  localparam int unsigned GW  = ice_pkg::GROUP_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS     = 4'd1;
  localparam logic [3:0] S_PUT     = 4'd2;
  localparam logic [3:0] S_EVAL    = 4'd3;
  localparam logic [3:0] S_SC_RDI  = 4'd4;
  localparam logic [3:0] S_SC_BASE = 4'd5;
  localparam logic [3:0] S_SC_RDJ  = 4'd6;
  localparam logic [3:0] S_SC_CMP  = 4'd7;
  localparam logic [3:0] S_SC_RUN  = 4'd8;
  localparam logic [3:0] S_SC_END  = 4'd9;
  localparam logic [3:0] S_SUM_RD  = 4'd10;
  localparam logic [3:0] S_SUM_ACC = 4'd11;
  localparam logic [3:0] S_DIV     = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  // control state
  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic                last_q, last_d;
  logic [SW_-1:0]      window_q, window_d;
  logic                out_valid_q, out_valid_d;

  // datapath
  ice_pkg::out_item_t  out_data_q, out_data_d;
  logic [SW_-1:0]      key_q, key_d;
  logic [AW-1:0]       ins_j_q, ins_j_d;
  logic [SW_-1:0]      smp_a_q, smp_a_d, smp_b_q, smp_b_d, smp_c_q, smp_c_d;
  logic [CW-1:0]       i_q, i_d, j_q, j_d;
  logic [SW_-1:0]      base_q, base_d;
  logic [CW-1:0]       best_q, best_d, best_start_q, best_start_d;
  logic [CW-1:0]       ptr_q, ptr_d, rem_cnt_q, rem_cnt_d, len_q, len_d;
  logic [SUMW-1:0]     sum_q, sum_d;
  logic [CW-1:0]       drem_q, drem_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;

  // RAM ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SW_-1:0]      ram_wdata, ram_rdata;

  // combinational helpers
  logic [CW-1:0]       cm1;
  logic [CW-1:0]       run;
  logic [SW_-1:0]      diff;
  logic [SW_-1:0]      dab, dbc, dac;
  logic [SW_:0]        pair;
  logic [CW:0]         trial, trial_sub;
  logic [GW+CW-1:0]    grp_ext;

  ice_ram #(
    .WIDTH (SW_),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    cm1       = count_q - CW'(1);
    run       = j_q - i_q;
    diff      = ram_rdata - base_q;
    dab       = (smp_a_q > smp_b_q) ? smp_a_q - smp_b_q : smp_b_q - smp_a_q;
    dbc       = (smp_c_q > smp_b_q) ? smp_c_q - smp_b_q : smp_b_q - smp_c_q;
    dac       = (smp_c_q > smp_a_q) ? smp_c_q - smp_a_q : smp_a_q - smp_c_q;
    trial     = {drem_q, sum_q[SUMW-1]};
    trial_sub = trial - {1'b0, len_q};
    grp_ext   = {{GW{1'b0}}, len_q};
    if ((dab < dbc) && (dab < dac)) begin
      pair = {1'b0, smp_a_q} + {1'b0, smp_b_q};
    end else if ((dbc < dab) && (dbc < dac)) begin
      pair = {1'b0, smp_b_q} + {1'b0, smp_c_q};
    end else begin
      pair = {1'b0, smp_a_q} + {1'b0, smp_c_q};
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    window_d     = window_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    key_d        = key_q;
    ins_j_d      = ins_j_q;
    smp_a_d      = smp_a_q;
    smp_b_d      = smp_b_q;
    smp_c_d      = smp_c_q;
    i_d          = i_q;
    j_d          = j_q;
    base_d       = base_q;
    best_d       = best_q;
    best_start_d = best_start_q;
    ptr_d        = ptr_q;
    rem_cnt_d    = rem_cnt_q;
    len_d        = len_q;
    sum_d        = sum_q;
    drem_d       = drem_q;
    dcnt_d       = dcnt_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    if (cfg_we_i) begin
      window_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d  = in_data_i.sample_distance;
          last_d = in_data_i.last_of_list;
          if (count_q == CW'(MAX_SAMPLES)) begin
            ovf_d = 1'b1;
            if (in_data_i.last_of_list) begin
              state_d = S_EVAL;
            end
          end else begin
            // first three samples in arrival order, for the three-sample rule
            if (count_q == CW'(0)) smp_a_d = in_data_i.sample_distance;
            if (count_q == CW'(1)) smp_b_d = in_data_i.sample_distance;
            if (count_q == CW'(2)) smp_c_d = in_data_i.sample_distance;
            if (count_q == CW'(0)) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_data_i.sample_distance;
              count_d   = count_q + CW'(1);
              if (in_data_i.last_of_list) begin
                state_d = S_EVAL;
              end
            end else begin
              ins_j_d   = cm1[AW-1:0];
              ram_raddr = cm1[AW-1:0];
              state_d   = S_INS;
            end
          end
        end
      end
      S_INS: begin
        // entry ins_j arrives; shift it up or drop the key above it
        ram_we    = 1'b1;
        ram_waddr = ins_j_q + AW'(1);
        if (ram_rdata > key_q) begin
          ram_wdata = ram_rdata;
          if (ins_j_q == '0) begin
            state_d = S_PUT;
          end else begin
            ins_j_d   = ins_j_q - AW'(1);
            ram_raddr = ins_j_q - AW'(1);
          end
        end else begin
          ram_wdata = key_q;
          count_d   = count_q + CW'(1);
          state_d   = last_q ? S_EVAL : S_IDLE;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        count_d   = count_q + CW'(1);
        state_d   = last_q ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        if (count_q <= CW'(2)) begin
          ptr_d     = '0;
          len_d     = count_q;
          rem_cnt_d = count_q;
          sum_d     = '0;
          state_d   = S_SUM_RD;
        end else if (count_q == CW'(3)) begin
          // mean of the pair is a plain halving
          sum_d   = SUMW'(pair[SW_:1]);
          len_d   = CW'(2);
          state_d = S_OUT;
        end else begin
          i_d          = '0;
          j_d          = '0;
          best_d       = '0;
          best_start_d = '0;
          state_d      = S_SC_RDI;
        end
      end
      S_SC_RDI: begin
        ram_raddr = i_q[AW-1:0];
        state_d   = S_SC_BASE;
      end
      S_SC_BASE: begin
        // run end never moves back; it only has to stay at or past the start
        base_d = ram_rdata;
        if (j_q < i_q) begin
          j_d = i_q;
        end
        state_d = S_SC_RDJ;
      end
      S_SC_RDJ: begin
        if (j_q == count_q) begin
          state_d = S_SC_RUN;
        end else begin
          ram_raddr = j_q[AW-1:0];
          state_d   = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        if (diff < window_q) begin
          j_d     = j_q + CW'(1);
          state_d = S_SC_RDJ;
        end else begin
          state_d = S_SC_RUN;
        end
      end
      S_SC_RUN: begin
        if (run > best_q) begin
          best_d       = run;
          best_start_d = i_q;
        end
        if (i_q == cm1) begin
          state_d = S_SC_END;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_SC_RDI;
        end
      end
      S_SC_END: begin
        // no real cluster: average the whole list
        if (best_q <= CW'(1)) begin
          ptr_d     = '0;
          len_d     = count_q;
          rem_cnt_d = count_q;
        end else begin
          ptr_d     = best_start_q;
          len_d     = best_q;
          rem_cnt_d = best_q;
        end
        sum_d   = '0;
        state_d = S_SUM_RD;
      end
      S_SUM_RD: begin
        ram_raddr = ptr_q[AW-1:0];
        state_d   = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        sum_d     = sum_q + SUMW'(ram_rdata);
        ptr_d     = ptr_q + CW'(1);
        rem_cnt_d = rem_cnt_q - CW'(1);
        if (rem_cnt_q == CW'(1)) begin
          drem_d  = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end else begin
          state_d = S_SUM_RD;
        end
      end
      S_DIV: begin
        // restoring divide, quotient shifts into sum_q from the bottom
        if (trial >= {1'b0, len_q}) begin
          drem_d = trial_sub[CW-1:0];
          sum_d  = {sum_q[SUMW-2:0], 1'b1};
        end else begin
          drem_d = trial[CW-1:0];
          sum_d  = {sum_q[SUMW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(SUMW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                   = 1'b1;
          out_data_d.consensus_distance = sum_q[SW_-1:0];
          out_data_d.samples_averaged   = grp_ext[GW-1:0];
          out_data_d.overflowed         = ovf_q;
          count_d                       = '0;
          ovf_d                         = 1'b0;
          state_d                       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      window_q    <= ice_pkg::WINDOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      window_q    <= window_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    key_q        <= key_d;
    ins_j_q      <= ins_j_d;
    smp_a_q      <= smp_a_d;
    smp_b_q      <= smp_b_d;
    smp_c_q      <= smp_c_d;
    i_q          <= i_d;
    j_q          <= j_d;
    base_q       <= base_d;
    best_q       <= best_d;
    best_start_q <= best_start_d;
    ptr_q        <= ptr_d;
    rem_cnt_q    <= rem_cnt_d;
    len_q        <= len_d;
    sum_q        <= sum_d;
    drem_q       <= drem_d;
    dcnt_q       <= dcnt_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_ins_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (CW'(ins_j_q) < count_q))
    else $error("insertion pointer outside stored samples");

  a_group_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> ((len_q != '0) && (len_q <= count_q)))
    else $error("averaged group empty or larger than the list");

endmodule

/* verif/tb_interval_consensus_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_consensus_estimator
// Self-checking bench: sample lists go in over valid/ready, each closed list
// is scored against a behavioral consensus predictor under several windows.
// ----------------------------------------------------------------------------
module tb_interval_consensus_estimator;

  localparam int unsigned SAMPLE_W      = ice_pkg::SAMPLE_W;
  localparam int unsigned GROUP_W       = ice_pkg::GROUP_W;
  localparam logic [SAMPLE_W-1:0] WINDOW_RESET = ice_pkg::WINDOW_RESET;
  localparam int unsigned STORE_DEPTH   = 64;
  localparam int unsigned SETTLE_CYCLES = 1000;   // worst insert + scan + divide
  localparam int unsigned LONG_HOLD     = 4000;
  localparam longint      TIMEOUT_NS    = 30000000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef enum int {SPREAD_UNIFORM, SPREAD_CLUSTER, SPREAD_EXTREME, SPREAD_REPEAT} spread_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  ice_pkg::in_item_t   in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ice_pkg::out_item_t  out_data_o;

  interval_consensus_estimator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [SAMPLE_W-1:0] list_samples [STORE_DEPTH];
  int unsigned         list_fill;
  bit                  list_dropped;
  logic [SAMPLE_W-1:0] window_now = WINDOW_RESET;
  ice_pkg::out_item_t  consensus_q [$];

  ice_pkg::in_item_t pending [$];
  int unsigned gap_pct, stall_pct;
  int unsigned gap_left, stall_left, hold_left;
  logic        hold_kick = 1'b0;

  int unsigned mismatches, results_seen, lists_closed, samples_taken, samples_dropped;
  int unsigned overflow_lists, windows_used;

  function automatic ice_pkg::out_item_t consensus_of_list();
    logic [SAMPLE_W-1:0] ordered [STORE_DEPTH];
    logic [SAMPLE_W-1:0] key, a, b, c, dab, dbc, dac;
    longint unsigned     sum;
    int unsigned         n, i, j, run, best, best_start;
    ice_pkg::out_item_t  r;
    n = list_fill;
    r.overflowed = list_dropped;
    if (n <= 2) begin
      sum = 0;
      for (i = 0; i < n; i++) sum += list_samples[i];
      r.consensus_distance = SAMPLE_W'(sum / n);
      r.samples_averaged   = GROUP_W'(n);
    end else if (n == 3) begin
      a = list_samples[0];
      b = list_samples[1];
      c = list_samples[2];
      dab = (a > b) ? a - b : b - a;
      dbc = (c > b) ? c - b : b - c;
      dac = (c > a) ? c - a : a - c;
      if (dab < dbc && dab < dac) sum = longint'(a) + b;
      else if (dbc < dab && dbc < dac) sum = longint'(b) + c;
      else sum = longint'(a) + c;  // any tie falls to the outer pair
      r.consensus_distance = SAMPLE_W'(sum / 2);
      r.samples_averaged   = GROUP_W'(2);
    end else begin
      for (i = 0; i < n; i++) begin
        key = list_samples[i];
        j = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      best = 0;
      best_start = 0;
      for (i = 0; i < n; i++) begin
        run = 0;
        for (j = i; j < n; j++)
          if (ordered[j] - ordered[i] < window_now) run++;
        if (run > best) begin
          best = run;
          best_start = i;
        end
      end
      // only singleton runs: fall back to the whole list
      if (best <= 1) begin
        best = n;
        best_start = 0;
      end
      sum = 0;
      for (i = 0; i < best; i++) sum += ordered[best_start + i];
      r.consensus_distance = SAMPLE_W'(sum / best);
      r.samples_averaged   = GROUP_W'(best);
    end
    return r;
  endfunction

  function automatic void take_sample(ice_pkg::in_item_t it);
    samples_taken++;
    if (list_fill < STORE_DEPTH) begin
      list_samples[list_fill] = it.sample_distance;
      list_fill++;
    end else begin
      list_dropped = 1'b1;
      samples_dropped++;
    end
    if (it.last_of_list) begin
      if (list_dropped) overflow_lists++;
      consensus_q.insert(consensus_q.size(), consensus_of_list());
      list_fill    = 0;
      list_dropped = 1'b0;
      lists_closed++;
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at result %0d: %s", results_seen, msg);
  endfunction

  // driver: one transfer in flight at most, bursts of idle cycles in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) take_sample(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending.pop_front();
          if (gap_pct != 0 && $urandom_range(99) < gap_pct) gap_left <= $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (hold_kick) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    ice_pkg::out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (consensus_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: dist %0d group %0d ovf %0d",
                                  out_data_o.consensus_distance,
                                  out_data_o.samples_averaged, out_data_o.overflowed));
        end else begin
          want = consensus_q.pop_front();
          if (out_data_o.consensus_distance !== want.consensus_distance)
            flag_mismatch($sformatf("consensus_distance expected %0d, got %0d",
                                    want.consensus_distance, out_data_o.consensus_distance));
          if (out_data_o.samples_averaged !== want.samples_averaged)
            flag_mismatch($sformatf("samples_averaged expected %0d, got %0d",
                                    want.samples_averaged, out_data_o.samples_averaged));
          if (out_data_o.overflowed !== want.overflowed)
            flag_mismatch($sformatf("overflowed expected %0d, got %0d",
                                    want.overflowed, out_data_o.overflowed));
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 17);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic add_sample(input logic [SAMPLE_W-1:0] value, input bit last);
    ice_pkg::in_item_t it;
    it.sample_distance = value;
    it.last_of_list    = last;
    pending.insert(pending.size(), it);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(spread_e style,
                                                      logic [SAMPLE_W-1:0] base);
    longint unsigned v;
    int unsigned     span;
    case (style)
      SPREAD_CLUSTER: begin
        if ($urandom_range(3) == 0) return SAMPLE_W'($urandom);
        span = 2 * window_now + 1;
        v = longint'(base) + $urandom_range(0, span);
      end
      SPREAD_EXTREME: begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 1;
          2: v = SAMPLE_MAX - 1;
          default: v = SAMPLE_MAX;
        endcase
      end
      SPREAD_REPEAT: v = longint'(base) + $urandom_range(0, 3);
      default: return SAMPLE_W'($urandom);
    endcase
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic queue_random_lists(input int unsigned budget);
    int unsigned         made, len, pick, k;
    spread_e             style;
    logic [SAMPLE_W-1:0] base;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) len = $urandom_range(1, 3);
      else if (pick < 80) len = $urandom_range(4, 12);
      else if (pick < 95) len = $urandom_range(13, 40);
      else len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 8);
      style = spread_e'($urandom_range(3));
      base  = SAMPLE_W'($urandom);
      for (k = 0; k < len; k++) add_sample(draw_sample(style, base), k == len - 1);
      made += len;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || consensus_q.size() != 0);
  endtask

  // only called once the block is idle; trailing cycles cover any late work
  task automatic set_window(input logic [SAMPLE_W-1:0] w, input int unsigned gp,
                            input int unsigned sp);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    gap_pct     <= gp;
    stall_pct   <= sp;
    window_now  = w;
    windows_used++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    gap_pct   = 25;
    stall_pct = 25;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: single, double, triple (first two or last two closest, and a tie), clustered, spread out
    windows_used = 1;
    add_sample(0, 1);
    add_sample(SAMPLE_MAX, 1);
    add_sample(SAMPLE_MAX, 0);
    add_sample(SAMPLE_MAX, 1);
    add_sample(10, 0);
    add_sample(12, 0);
    add_sample(100, 1);
    add_sample(100, 0);
    add_sample(10, 0);
    add_sample(12, 1);
    add_sample(0, 0);
    add_sample(5, 0);
    add_sample(10, 1);
    add_sample(100, 0);
    add_sample(5000, 0);
    add_sample(120, 0);
    add_sample(130, 1);
    add_sample(0, 0);
    add_sample(1000, 0);
    add_sample(2000, 0);
    add_sample(3000, 1);

    set_window(1, 30, 30);
    add_sample(7, 0);
    add_sample(9, 0);
    add_sample(7, 0);
    add_sample(7, 1);
    queue_random_lists(150);

    set_window(SAMPLE_MAX, 20, 40);
    add_sample(0, 0);
    add_sample(SAMPLE_MAX, 0);
    add_sample(SAMPLE_MAX, 0);
    add_sample(5, 1);
    queue_random_lists(200);

    // zero window: no cluster forms, lists of four or more samples are averaged whole
    set_window(0, 40, 10);
    add_sample(3, 0);
    add_sample(3, 0);
    add_sample(3, 0);
    add_sample(3, 1);
    queue_random_lists(100);

    // receiver goes away while the sender keeps offering, so input backs up
    set_window(SAMPLE_W'($urandom_range(2, 4000)), 0, 20);
    @(posedge clk_i);
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;
    queue_random_lists(300);

    set_window(SAMPLE_W'($urandom), 15, 15);
    queue_random_lists(300);

    set_window(WINDOW_RESET, 0, 0);
    queue_random_lists(350);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d consensus results for %0d lists from %0d samples over %0d windows",
             results_seen, lists_closed, samples_taken, windows_used);
    $display("%0d lists overran the store (%0d samples dropped); %0d mismatches",
             overflow_lists, samples_dropped, mismatches);
    if (consensus_q.size() != 0) $display("%0d expected results never arrived",
                                          consensus_q.size());
    if (mismatches == 0 && consensus_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", consensus_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
